// ===== hw/rtl/sesd_pkg.sv =====
// ----------------------------------------------------------------------------
// sesd_pkg
// shared types and constants of the string escape decoder
// ----------------------------------------------------------------------------
package sesd_pkg;

  // depth of the result queue, at least two so that one item always fits
  localparam int unsigned SESD_FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_DIGITS = 2'd2
  } mode_t;

  typedef struct packed {
    logic [31:0] decoded;
    logic        status;
    logic        last_of_run;
    logic        string_done;
  } result_t;

  // up to two results produced by one item, written into the queue together
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

// ===== hw/rtl/sesd_fifo.sv =====
// ----------------------------------------------------------------------------
// sesd_fifo
// result queue that takes up to two results a cycle and gives one a cycle
// ----------------------------------------------------------------------------
module sesd_fifo #(
  parameter int unsigned Depth = sesd_pkg::SESD_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  sesd_pkg::push_t   push,
  input  logic              pop,
  output sesd_pkg::result_t head,
  output logic              not_empty,
  output logic              room
);
  import sesd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t          entries [Depth];
  logic [PtrW-1:0]  rd_ptr;
  logic [PtrW-1:0]  rd_ptr_next;
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  wr_ptr_next;
  logic [PtrW-1:0]  wr_ptr_inc;
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  count_next;
  logic [1:0]       wr_n;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_n       = {1'b0, push.valid0} + {1'b0, push.valid1};
  assign wr_ptr_inc = ptr_inc(wr_ptr);

  always_comb begin
    case (wr_n)
      2'd1:    wr_ptr_next = wr_ptr_inc;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + CntW'(wr_n) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  // second result goes right behind the first
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.valid1) begin
      entries[wr_ptr_inc] <= push.r1;
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  // two free slots once this cycle's pop is counted
  assign room = (({1'b0, count} + (CntW + 1)'(2)) <=
                 ((CntW + 1)'(Depth) + {{CntW{1'b0}}, pop}));

endmodule

// ===== hw/rtl/sesd_core.sv =====
// ----------------------------------------------------------------------------
// sesd_core
// escape state and single-pass decode of one character into its results
// ----------------------------------------------------------------------------
module sesd_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [31:0]     cp,
  input  logic            eos,
  output sesd_pkg::push_t push
);
  import sesd_pkg::*;

  localparam logic [31:0] CH_BACKSLASH = 32'h5C;
  localparam logic [31:0] CH_QUOTE     = 32'h22;
  localparam logic [31:0] CH_APOS      = 32'h27;
  localparam logic [31:0] CH_QUESTION  = 32'h3F;
  localparam logic [31:0] CH_SLASH     = 32'h2F;
  localparam logic [31:0] CH_DIGIT_0   = 32'h30;
  localparam logic [31:0] CH_DIGIT_7   = 32'h37;
  localparam logic [31:0] CH_DIGIT_8   = 32'h38;
  localparam logic [31:0] CH_DIGIT_9   = 32'h39;
  localparam logic [31:0] CH_UPPER_A   = 32'h41;
  localparam logic [31:0] CH_UPPER_F   = 32'h46;
  localparam logic [31:0] CH_LOWER_A   = 32'h61;
  localparam logic [31:0] CH_LOWER_F   = 32'h66;
  localparam logic [31:0] CH_LOWER_X   = 32'h78;
  localparam logic [31:0] CH_UPPER_X   = 32'h58;
  localparam logic [31:0] CH_UPPER_U   = 32'h55;
  localparam logic [31:0] CH_LOWER_U   = 32'h75;
  localparam logic [31:0] CH_LOWER_B   = 32'h62;
  localparam logic [31:0] CH_LOWER_E   = 32'h65;
  localparam logic [31:0] CH_LOWER_N   = 32'h6E;
  localparam logic [31:0] CH_LOWER_R   = 32'h72;
  localparam logic [31:0] CH_LOWER_T   = 32'h74;
  localparam logic [31:0] CH_LOWER_V   = 32'h76;
  localparam logic [31:0] CTRL_LIMIT   = 32'd32;
  localparam logic [3:0]  LIMIT_HEX8   = 4'd8;
  localparam logic [3:0]  LIMIT_HEX4   = 4'd4;
  localparam logic [3:0]  LIMIT_OCT    = 4'd3;

  typedef enum logic [2:0] {
    ESC_SELF,
    ESC_HEX8,
    ESC_HEX4,
    ESC_OCT,
    ESC_MAPPED,
    ESC_BAD
  } esc_kind_t;

  mode_t       mode;
  mode_t       mode_next;
  logic [3:0]  digit_count;
  logic [3:0]  digit_count_next;
  logic [3:0]  digit_limit;
  logic [3:0]  digit_limit_next;
  logic        radix_hex;
  logic        radix_hex_next;
  logic [31:0] acc;
  logic [31:0] acc_next;

  esc_kind_t   esc_kind;
  logic [31:0] esc_value;
  logic [31:0] cp_low;
  logic        is_oct;
  logic        is_dec89;
  logic        is_hex_upper;
  logic        is_hex_lower;
  logic        d_valid;
  logic [3:0]  d_val;
  logic [31:0] acc_shift;
  logic [3:0]  cnt_inc;
  logic        run_done;
  logic        plain_silent;
  logic        plain_err;
  logic        v0;
  logic        v1;
  result_t     r0;
  result_t     r1;

  function automatic result_t make_result(input logic [31:0] value, input logic err);
    result_t r;
    r.decoded     = err ? 32'd0 : value;
    r.status      = err;
    r.last_of_run = 1'b0;
    r.string_done = 1'b0;
    return r;
  endfunction

  // character classes
  assign cp_low       = cp | 32'h20;
  assign is_oct       = (cp >= CH_DIGIT_0) && (cp <= CH_DIGIT_7);
  assign is_dec89     = (cp == CH_DIGIT_8) || (cp == CH_DIGIT_9);
  assign is_hex_upper = (cp >= CH_UPPER_A) && (cp <= CH_UPPER_F);
  assign is_hex_lower = (cp >= CH_LOWER_A) && (cp <= CH_LOWER_F);
  assign d_valid      = is_oct || (radix_hex && (is_dec89 || is_hex_upper || is_hex_lower));
  assign d_val        = (is_hex_upper || is_hex_lower) ? cp[3:0] + 4'd9 : cp[3:0];
  assign acc_shift    = radix_hex ? {acc[27:0], d_val} : {acc[28:0], d_val[2:0]};
  assign cnt_inc      = digit_count + 4'd1;
  assign run_done     = (cnt_inc >= digit_limit) || eos;
  assign plain_silent = (cp == CH_BACKSLASH) && !eos;
  assign plain_err    = (cp == CH_QUOTE) || (cp < CTRL_LIMIT) || (cp == CH_BACKSLASH);

  always_comb begin
    esc_kind  = ESC_BAD;
    esc_value = cp;
    case (cp) inside
      CH_BACKSLASH, CH_APOS, CH_QUOTE, CH_QUESTION, CH_SLASH: esc_kind = ESC_SELF;
      CH_LOWER_X, CH_UPPER_X, CH_UPPER_U:                     esc_kind = ESC_HEX8;
      CH_LOWER_U:                                             esc_kind = ESC_HEX4;
      [CH_DIGIT_0:CH_DIGIT_7]:                                esc_kind = ESC_OCT;
      default: begin
        esc_kind = ESC_MAPPED;
        case (cp_low)
          CH_LOWER_A: esc_value = 32'd7;
          CH_LOWER_B: esc_value = 32'd8;
          CH_LOWER_E: esc_value = 32'd27;
          CH_LOWER_F: esc_value = 32'd12;
          CH_LOWER_N: esc_value = 32'd10;
          CH_LOWER_R: esc_value = 32'd13;
          CH_LOWER_T: esc_value = 32'd9;
          CH_LOWER_V: esc_value = 32'd11;
          default:    esc_kind  = ESC_BAD;
        endcase
      end
    endcase
  end

  // next state
  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    digit_limit_next = digit_limit;
    radix_hex_next   = radix_hex;
    acc_next         = acc;
    if (advance) begin
      if (eos) begin
        mode_next        = MODE_PLAIN;
        digit_count_next = '0;
        digit_limit_next = '0;
        radix_hex_next   = 1'b0;
        acc_next         = '0;
      end else begin
        case (mode)
          MODE_ESC: begin
            mode_next = MODE_PLAIN;
            case (esc_kind)
              ESC_HEX8, ESC_HEX4: begin
                mode_next        = MODE_DIGITS;
                digit_limit_next = (esc_kind == ESC_HEX8) ? LIMIT_HEX8 : LIMIT_HEX4;
                radix_hex_next   = 1'b1;
                acc_next         = '0;
                digit_count_next = '0;
              end
              ESC_OCT: begin
                mode_next        = MODE_DIGITS;
                digit_limit_next = LIMIT_OCT;
                radix_hex_next   = 1'b0;
                acc_next         = {29'd0, cp[2:0]};
                digit_count_next = 4'd1;
              end
              default: mode_next = MODE_PLAIN;
            endcase
          end
          MODE_DIGITS: begin
            if (d_valid) begin
              acc_next         = acc_shift;
              digit_count_next = cnt_inc;
              if (run_done) begin
                mode_next = MODE_PLAIN;
              end
            end else begin
              mode_next = plain_silent ? MODE_ESC : MODE_PLAIN;
            end
          end
          default: mode_next = plain_silent ? MODE_ESC : MODE_PLAIN;
        endcase
      end
    end
  end

  // results of this item
  always_comb begin
    v0 = 1'b0;
    v1 = 1'b0;
    r0 = make_result(cp, plain_err);
    r1 = make_result(cp, plain_err);
    case (mode)
      MODE_ESC: begin
        case (esc_kind)
          ESC_SELF: begin
            v0 = 1'b1;
            r0 = make_result(cp, 1'b0);
          end
          ESC_MAPPED: begin
            v0 = 1'b1;
            r0 = make_result(esc_value, 1'b0);
          end
          ESC_HEX8, ESC_HEX4: begin
            v0 = eos;
            r0 = make_result(32'd0, 1'b1);
          end
          ESC_OCT: begin
            v0 = eos;
            r0 = make_result({29'd0, cp[2:0]}, 1'b0);
          end
          default: begin
            v0 = 1'b1;
            r0 = make_result(32'd0, 1'b1);
          end
        endcase
      end
      MODE_DIGITS: begin
        if (d_valid) begin
          v0 = run_done;
          r0 = make_result(acc_shift, cnt_inc == 4'd0);
        end else begin
          v0 = 1'b1;
          r0 = make_result(acc, digit_count == 4'd0);
          v1 = !plain_silent;
        end
      end
      default: v0 = !plain_silent;
    endcase
    if (v1) begin
      r1.last_of_run = 1'b1;
      r1.string_done = eos;
    end else begin
      r0.last_of_run = 1'b1;
      r0.string_done = eos;
    end
  end

  assign push.valid0 = v0 && advance;
  assign push.valid1 = v1 && advance;
  assign push.r0     = r0;
  assign push.r1     = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      digit_count <= '0;
      digit_limit <= '0;
      radix_hex   <= 1'b0;
      acc         <= '0;
    end else begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      digit_limit <= digit_limit_next;
      radix_hex   <= radix_hex_next;
      acc         <= acc_next;
    end
  end

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && eos) |-> push.valid0)
    else $error("end of string produced no result");

  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    (advance && eos) |=> (mode == MODE_PLAIN && acc == 32'd0 && digit_count == 4'd0))
    else $error("state not cleared after end of string");

  a_run_below_limit: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_DIGITS) |-> (digit_count < digit_limit))
    else $error("digit run past its limit");

  a_second_after_first: assert property (@(posedge clk) disable iff (rst)
    push.valid1 |-> (push.valid0 && !push.r0.last_of_run && push.r1.last_of_run))
    else $error("second result without a leading first result");

endmodule

// ===== hw/rtl/string_escape_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// string_escape_decoder_unit
// decodes a string literal body, one code point per request, into code points
// ----------------------------------------------------------------------------
// Each request carries one code point of a literal body plus an end-of-string
// flag; results come out in order with a status bit, a last-of-run flag on the
// final result of each request and a string-done flag on the final result of
// the string. A request is registered on entry, decoded in one pass against
// the escape state once the queue has room for two results, and its results
// are written into the queue that feeds the result port. The unit takes one
// request every cycle as long as the result side keeps up. Most requests give
// zero or one result; a digit run closed by a character that itself gives a
// result gives two, which leave the result port one at a time, so back-to-back
// two-result requests hold the rate below one request per cycle.
// A queue of FifoDepth results (at least two) sits in front of the result
// port, so requests keep flowing while results wait to be taken.
module string_escape_decoder_unit #(
  parameter int unsigned FifoDepth = sesd_pkg::SESD_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] code_point,
  input  logic        end_of_string,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] decoded,
  output logic        status,
  output logic        last_of_run,
  output logic        string_done
);
  import sesd_pkg::*;

  // input register
  logic        in_full;
  logic [31:0] in_cp;
  logic        in_eos;
  logic        accept;
  logic        advance;
  logic        room;
  logic        pop;
  push_t       push;
  result_t     head;

  // the held request moves on when the queue can take two results
  assign advance    = in_full && room;
  assign item_stall = in_full && !room;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_cp  <= code_point;
      in_eos <= end_of_string;
    end
  end

  // escape state and decode
  sesd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cp      (in_cp),
    .eos     (in_eos),
    .push    (push)
  );

  // result queue, head drives the result port
  sesd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (result_valid),
    .room      (room)
  );

  assign pop         = result_valid && !result_stall;
  assign decoded     = head.decoded;
  assign status      = head.status;
  assign last_of_run = head.last_of_run;
  assign string_done = head.string_done;

endmodule
